// ===== src/assert_macros.svh =====
// Assertion shorthands shared by the degree bucket queue modules.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge outside reset.
`define DBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define DBQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dbq_pkg.sv =====
// Shared types and constants for the degree bucket queue.
// Used by dbq_ctrl, dbq_datapath and degree_bucket_queue.
`default_nettype none

package dbq_pkg;

  // Default sizes
  localparam int DEF_NODES   = 256;
  localparam int DEF_BUCKETS = 32;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int NODE_W = 8;
  localparam int DEG_W  = 5;

  // Command codes
  localparam logic [CMD_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [CMD_W-1:0] OP_PEEK     = 2'd2;
  localparam logic [CMD_W-1:0] OP_RESERVED = 2'd3;

  // Input word
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] node;
    logic [DEG_W-1:0]  degree;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node_out;
    logic [DEG_W-1:0]  degree_out;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch input word, read memories
    logic remove;    // unlink node
    logic insert1;   // link node at bucket head
    logic insert2;   // back-link old head to new node
    logic load_out;  // load result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             args_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/dbq_ctrl.sv =====
// Controller state machine for the degree bucket queue.
// Depends on dbq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire dbq_pkg::dp_status_t status,
  output dbq_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_INS2 = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  // result register can take a new word this cycle
  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.op == dbq_pkg::OP_INSERT && status.args_ok) begin
          cmd.insert1 = 1'b1;
          state_nxt   = ST_INS2;
        end else if (slot_free) begin
          cmd.remove   = (status.op == dbq_pkg::OP_REMOVE) && status.args_ok;
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_INS2: begin
        if (slot_free) begin
          cmd.insert2  = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `DBQ_ASSERT(a_no_overwrite, cmd.load_out |-> slot_free, "result overwritten before taken")
  `DBQ_ASSERT_NEXT(a_one_item, cmd.accept, !in_ready, "second word taken while busy")
  `DBQ_ASSERT(a_one_action, $onehot0({cmd.accept, cmd.remove, cmd.insert1, cmd.insert2}), "conflicting datapath commands")

endmodule

`default_nettype wire

// ===== src/dbq_datapath.sv =====
// Datapath: bucket heads, link memories, nonempty bitmap and result register.
// Depends on dbq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dbq_datapath #(
  parameter int NODES   = dbq_pkg::DEF_NODES,
  parameter int BUCKETS = dbq_pkg::DEF_BUCKETS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dbq_pkg::in_word_t  in_data,
  input  wire dbq_pkg::ctrl_cmd_t cmd,
  output dbq_pkg::dp_status_t     status,
  output dbq_pkg::out_word_t      out_data
);

  localparam int NW = $clog2(NODES);
  localparam int LW = $clog2(NODES + 1);
  localparam int BW = $clog2(BUCKETS);
  localparam logic [LW-1:0] NIL = LW'(NODES);

  // storage
  logic [LW-1:0]      next_mem [NODES];
  logic [LW-1:0]      prev_mem [NODES];
  logic [LW-1:0]      head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld_r;
  logic [BUCKETS-1:0] map_r;

  // latched word and read data
  logic [dbq_pkg::CMD_W-1:0] op_r;
  logic [LW-1:0]             node_r;
  logic [BW-1:0]             deg_r;
  logic                      args_ok_r;
  logic [BW-1:0]             low_r;
  logic                      found_r;
  logic [LW-1:0]             next_rd_r, prev_rd_r, head_rd_r;
  logic                      head_hit_r;
  dbq_pkg::out_word_t        out_r;

  logic [LW-1:0] node_in;
  logic [BW-1:0] deg_in;
  logic          args_ok;
  logic [BW-1:0] low;
  logic [BW-1:0] head_raddr;
  logic [LW-1:0] hd, p, q, rem_head;
  logic          head_we;
  logic [LW-1:0] head_wdata;

  assign node_in = LW'(in_data.node);
  assign deg_in  = BW'(in_data.degree);
  assign args_ok = (int'(in_data.node) < NODES) && (int'(in_data.degree) < BUCKETS);

  // lowest nonempty bucket
  always_comb begin
    low = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) begin
      if (map_r[i]) begin
        low = BW'(i);
      end
    end
  end

  assign head_raddr = (in_data.command == dbq_pkg::OP_PEEK) ? low : deg_in;

  // read values used in the execute step
  assign hd = head_hit_r ? head_rd_r : NIL;
  assign p  = prev_rd_r;
  assign q  = next_rd_r;
  // bucket head after a remove
  assign rem_head = (p < NIL) ? hd : q;

  assign status.op      = op_r;
  assign status.args_ok = args_ok_r;

  // latch word and read all three memories
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_data.command;
      node_r     <= node_in;
      deg_r      <= deg_in;
      args_ok_r  <= args_ok;
      low_r      <= low;
      found_r    <= |map_r;
      next_rd_r  <= next_mem[node_in[NW-1:0]];
      prev_rd_r  <= prev_mem[node_in[NW-1:0]];
      head_rd_r  <= head_mem[head_raddr];
      head_hit_r <= head_vld_r[head_raddr];
    end
  end

  // next link memory
  always_ff @(posedge clk) begin
    if (cmd.remove && (p < NIL)) begin
      next_mem[p[NW-1:0]] <= q;
    end else if (cmd.insert1) begin
      next_mem[node_r[NW-1:0]] <= hd;
    end
  end

  // prev link memory
  always_ff @(posedge clk) begin
    if (cmd.remove && (q < NIL)) begin
      prev_mem[q[NW-1:0]] <= p;
    end else if (cmd.insert1) begin
      prev_mem[node_r[NW-1:0]] <= NIL;
    end else if (cmd.insert2 && (hd < NIL)) begin
      prev_mem[hd[NW-1:0]] <= node_r;
    end
  end

  // bucket head memory
  assign head_we    = cmd.insert1 || (cmd.remove && !(p < NIL));
  assign head_wdata = cmd.insert1 ? node_r : q;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[deg_r] <= head_wdata;
    end
  end

  // head valid bits and nonempty bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
      map_r      <= '0;
    end else begin
      if (head_we) begin
        head_vld_r[deg_r] <= 1'b1;
      end
      if (cmd.insert1) begin
        map_r[deg_r] <= 1'b1;
      end else if (cmd.remove && !(rem_head < NIL)) begin
        map_r[deg_r] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (op_r == dbq_pkg::OP_PEEK && found_r) begin
        out_r.found      <= 1'b1;
        out_r.node_out   <= (hd < NIL) ? dbq_pkg::NODE_W'(hd) : '0;
        out_r.degree_out <= dbq_pkg::DEG_W'(low_r);
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_data = out_r;

  `DBQ_ASSERT(a_peek_bit, (cmd.load_out && op_r == dbq_pkg::OP_PEEK && found_r) |-> map_r[low_r], "peek reports an empty bucket")

endmodule

`default_nettype wire

// ===== src/degree_bucket_queue.sv =====
// Top level of the degree bucket queue: controller plus datapath.
// Depends on dbq_pkg, dbq_ctrl and dbq_datapath.
`default_nettype none

// Bucket queue of nodes grouped by degree, with doubly linked bucket lists
// and a nonempty bitmap. Every word in gives exactly one result word: peek
// reports the lowest nonempty bucket and its head node, insert, remove and
// the reserved command return all zeros. One word is handled at a time:
// remove, peek and reserved pass through the execute step before the
// next acceptance, insert through a second step too, as it writes the
// prev-link memory twice through its single write port. A stalled result
// holds the block in its last step. Bucket heads reset through valid bits,
// so the block is ready right after reset with no clearing pass. Removing
// a node that is not in the named bucket leaves the lists meaningless.
module degree_bucket_queue #(
  parameter int NODES   = dbq_pkg::DEF_NODES,
  parameter int BUCKETS = dbq_pkg::DEF_BUCKETS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dbq_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dbq_pkg::out_word_t      out_data
);

  dbq_pkg::ctrl_cmd_t  cmd;
  dbq_pkg::dp_status_t status;

  dbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dbq_datapath #(
    .NODES   (NODES),
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_degree_bucket_queue.sv =====
// Self-checking testbench for degree_bucket_queue: directed and random command words.
// Depends on dbq_pkg and degree_bucket_queue.
`timescale 1ns / 1ps

module tb_degree_bucket_queue;

  localparam int NUM_NODES   = 256;
  localparam int NUM_BUCKETS = 32;
  localparam logic [8:0] NIL_LINK = 9'd256;  // empty mark for heads and links
  localparam int RANDOM_WORDS = 820;
  localparam int IDLE_PCT = 22;

  // Shadow of the bucket lists; predicts one result word per command word
  class bucket_scoreboard;
    logic [8:0]  head_of [NUM_BUCKETS];
    logic [8:0]  next_of [NUM_NODES];
    logic [8:0]  prev_of [NUM_NODES];
    logic [31:0] busy_map;
    dbq_pkg::out_word_t pending_results[$];
    int          errors;
    int          checked;
    int          peek_hits;

    function new();
      for (int i = 0; i < NUM_BUCKETS; i++) head_of[i] = NIL_LINK;
      for (int i = 0; i < NUM_NODES; i++) begin
        next_of[i] = '0;
        prev_of[i] = '0;
      end
      busy_map = '0;
      errors = 0;
      checked = 0;
      peek_hits = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Accepted command word: update the shadow lists, queue the expected result
    function void note_word(dbq_pkg::in_word_t w);
      dbq_pkg::out_word_t res;
      logic [7:0] n;
      logic [4:0] d;
      logic [8:0] h, p, q;
      int         low;
      res = '0;
      n = w.node;
      d = w.degree;
      case (w.command)
        dbq_pkg::OP_INSERT: begin
          h = head_of[d];
          prev_of[n] = NIL_LINK;
          next_of[n] = h;
          if (h < NIL_LINK) prev_of[h[7:0]] = {1'b0, n};
          head_of[d] = {1'b0, n};
          busy_map[d] = 1'b1;
        end
        dbq_pkg::OP_REMOVE: begin
          p = prev_of[n];
          q = next_of[n];
          if (p < NIL_LINK) next_of[p[7:0]] = q;
          else head_of[d] = q;
          if (q < NIL_LINK) prev_of[q[7:0]] = p;
          if (head_of[d] >= NIL_LINK) busy_map[d] = 1'b0;
        end
        dbq_pkg::OP_PEEK: begin
          if (busy_map != '0) begin
            low = 0;
            while (low < 31 && !busy_map[low]) low++;
            h = head_of[low];
            res.found = 1'b1;
            res.node_out = (h < NIL_LINK) ? h[7:0] : 8'd0;
            res.degree_out = low[4:0];
            peek_hits++;
          end
        end
        default: ;  // reserved: all-zero result, no state change
      endcase
      pending_results.push_back(res);
    endfunction

    // Accepted result word: compare with the oldest expectation
    function void check_word(dbq_pkg::out_word_t got);
      dbq_pkg::out_word_t exp_w;
      if (pending_results.size() == 0) begin
        $error("result word %h arrived with nothing pending", got);
        errors++;
        return;
      end
      exp_w = pending_results.pop_front();
      checked++;
      if (got.found !== exp_w.found) begin
        $error("found: expected %0d, got %0d", exp_w.found, got.found);
        errors++;
      end
      if (got.node_out !== exp_w.node_out) begin
        $error("node_out: expected %0d, got %0d", exp_w.node_out, got.node_out);
        errors++;
      end
      if (got.degree_out !== exp_w.degree_out) begin
        $error("degree_out: expected %0d, got %0d", exp_w.degree_out, got.degree_out);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  dbq_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  dbq_pkg::out_word_t out_data;

  bucket_scoreboard sb;

  // Stimulus-side bookkeeping: which bucket each node was last put in
  int   bucket_of [NUM_NODES];  // -1 when not queued
  bit   ever_linked [NUM_NODES];  // links written at least once
  byte unsigned queued_nodes[$];
  byte unsigned linked_nodes[$];
  bit   steady;  // no idling on either side
  int   words_sent;

  degree_bucket_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Handshake monitors
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Drive one word, with random idle cycles in front, and wait for acceptance
  task automatic send_word(input dbq_pkg::in_word_t w);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Send a command and keep the membership bookkeeping in step
  task automatic issue(input logic [dbq_pkg::CMD_W-1:0] cmd, input int n, input int d);
    dbq_pkg::in_word_t w;
    w.command = cmd;
    w.node = n[7:0];
    w.degree = d[4:0];
    if (cmd == dbq_pkg::OP_INSERT) begin
      if (bucket_of[n] < 0) queued_nodes.push_back(n[7:0]);
      if (!ever_linked[n]) linked_nodes.push_back(n[7:0]);
      bucket_of[n] = d;
      ever_linked[n] = 1'b1;
    end else if (cmd == dbq_pkg::OP_REMOVE && bucket_of[n] >= 0) begin
      foreach (queued_nodes[i])
        if (queued_nodes[i] == n) begin
          queued_nodes.delete(i);
          break;
        end
      bucket_of[n] = -1;
    end
    send_word(w);
  endtask

  // Stop sending until every expected result is back
  task automatic hold_until_empty();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic int pick_degree();
    return $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31);
  endfunction

  // One random word: mostly well-formed list traffic, some broken sequences
  task automatic random_word();
    int sel, n, idx;
    sel = $urandom_range(0, 99);
    if (sel < 40 && queued_nodes.size() < NUM_NODES) begin
      do n = $urandom_range(0, NUM_NODES - 1); while (bucket_of[n] >= 0);
      issue(dbq_pkg::OP_INSERT, n, pick_degree());
    end else if (sel < 70 && queued_nodes.size() > 0) begin
      idx = $urandom_range(0, queued_nodes.size() - 1);
      n = queued_nodes[idx];
      issue(dbq_pkg::OP_REMOVE, n, bucket_of[n]);
    end else if (sel < 90) begin
      issue(dbq_pkg::OP_PEEK, $urandom_range(0, 255), $urandom_range(0, 31));
    end else if (sel < 94) begin
      issue(dbq_pkg::OP_RESERVED, $urandom_range(0, 255), $urandom_range(0, 31));
    end else if (sel < 97 && linked_nodes.size() > 0) begin
      // remove from a bucket the node may not be in
      n = linked_nodes[$urandom_range(0, linked_nodes.size() - 1)];
      issue(dbq_pkg::OP_REMOVE, n, $urandom_range(0, 31));
    end else if (queued_nodes.size() > 0) begin
      // link an already queued node again
      n = queued_nodes[$urandom_range(0, queued_nodes.size() - 1)];
      issue(dbq_pkg::OP_INSERT, n, pick_degree());
    end else begin
      issue(dbq_pkg::OP_PEEK, 0, 0);
    end
  endtask

  // Empty every tracked bucket, peeking along the way
  task automatic drain_buckets();
    int n;
    while (queued_nodes.size() > 0) begin
      n = queued_nodes[$urandom_range(0, queued_nodes.size() - 1)];
      issue(dbq_pkg::OP_REMOVE, n, bucket_of[n]);
      if ($urandom_range(0, 2) == 0) issue(dbq_pkg::OP_PEEK, 0, 0);
    end
    issue(dbq_pkg::OP_PEEK, 255, 31);
  endtask

  // Main sequence
  initial begin
    sb = new();
    foreach (bucket_of[i]) begin
      bucket_of[i] = -1;
      ever_linked[i] = 1'b0;
    end
    steady = 1'b0;
    words_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty peek, extremes, head/middle/tail unlink, bucket emptying
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_RESERVED, 255, 31);
    issue(dbq_pkg::OP_INSERT, 0, 0);
    issue(dbq_pkg::OP_INSERT, 255, 31);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_INSERT, 170, 31);
    issue(dbq_pkg::OP_PEEK, 85, 10);
    issue(dbq_pkg::OP_REMOVE, 0, 0);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_REMOVE, 255, 31);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_REMOVE, 170, 31);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_INSERT, 1, 5);
    issue(dbq_pkg::OP_INSERT, 2, 5);
    issue(dbq_pkg::OP_INSERT, 3, 5);
    issue(dbq_pkg::OP_REMOVE, 2, 5);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_REMOVE, 3, 5);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_REMOVE, 1, 5);
    issue(dbq_pkg::OP_PEEK, 0, 0);
    issue(dbq_pkg::OP_RESERVED, 85, 10);
    hold_until_empty();

    // Random traffic with two full drains and a stretch without idling
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      steady = (k >= 400 && k < 550);
      if (k == 300 || k == 700) begin
        hold_until_empty();
        drain_buckets();
      end
      random_word();
    end
    steady = 1'b0;
    drain_buckets();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d command words; checked %0d result words, %0d peeks found a bucket.",
             words_sent, sb.checked, sb.peek_hits);
    if (sb.errors == 0) begin
      $display("degree_bucket_queue verification clean");
    end else begin
      $display("degree_bucket_queue verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("degree_bucket_queue verification failed");
    $finish;
  end

endmodule
